// File: rtl/lifo_pkg.sv
`timescale 1ns / 1ps
// Package for the LIFO stack unit: operation and status codes, controller
// state type and the command struct passed from controller to datapath.
// No dependencies.
package lifo_pkg;

    localparam int FUNC_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BOUNDS    = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // carry out the captured operation
    } t_dp_cmd;

endpackage

// File: rtl/lifo_if.sv
`timescale 1ns / 1ps
// Handshake interfaces for the LIFO stack unit: command channel and
// response channel, each valid/ready with its payload. Uses lifo_pkg.
interface lifo_in_if #(
    parameter int IDX_W = 3
);
    logic                           valid;
    logic                           ready;
    logic [lifo_pkg::FUNC_W-1:0]    func;
    logic [IDX_W-1:0]               index;
    logic signed [lifo_pkg::WORD_W-1:0] value;

    modport source (output valid, func, index, value, input ready);
    modport sink   (input valid, func, index, value, output ready);
endinterface

interface lifo_out_if #(
    parameter int CNT_W = 4
);
    logic                               valid;
    logic                               ready;
    logic signed [lifo_pkg::WORD_W-1:0] data;
    logic [lifo_pkg::STATUS_W-1:0]      status;
    logic [CNT_W-1:0]                   count;
    logic                               empty_res;
    logic                               full_res;

    modport source (output valid, data, status, count, empty_res, full_res, input ready);
    modport sink   (input valid, data, status, count, empty_res, full_res, output ready);
endinterface

// File: rtl/lifo_ctrl.sv
`timescale 1ns / 1ps
// Controller for the LIFO stack unit: sequences capture, execution and
// response of one command word at a time. Uses lifo_pkg.
module lifo_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lifo_pkg::t_dp_cmd o_cmd
);
    import lifo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EXEC;
            S_EXEC: n_state = S_OUT;
            S_OUT:  if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec  = (r_state == S_EXEC);

endmodule

// File: rtl/lifo_dp.sv
`timescale 1ns / 1ps
// Datapath for the LIFO stack unit: entry memory, fill count, bounds checks
// and response registers. Uses lifo_pkg.
module lifo_dp #(
    parameter int DEPTH = 8,
    parameter int IDX_W = $clog2(DEPTH),
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lifo_pkg::t_dp_cmd                   i_cmd,
    input  logic [lifo_pkg::FUNC_W-1:0]         i_func,
    input  logic [IDX_W-1:0]                    i_index,
    input  logic signed [lifo_pkg::WORD_W-1:0]  i_value,
    output logic signed [lifo_pkg::WORD_W-1:0]  o_data,
    output logic [lifo_pkg::STATUS_W-1:0]       o_status,
    output logic [CNT_W-1:0]                    o_count,
    output logic                                o_empty,
    output logic                                o_full
);
    import lifo_pkg::*;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [FUNC_W-1:0]          r_func;
    logic [IDX_W-1:0]           r_idx;
    logic signed [WORD_W-1:0]   r_value;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic [STATUS_W-1:0]        r_status;
    logic [STATUS_W-1:0]        n_status;
    logic                       r_hit;
    logic signed [WORD_W-1:0]   r_rd_data;
    logic signed [WORD_W-1:0]   r_mem [DEPTH];

    logic                       wr_en;
    logic                       rd_en;
    logic [IDX_W-1:0]           addr;
    logic                       is_empty;
    logic                       is_full;
    logic [CNT_W-1:0]           cnt_dec;

    assign is_empty = (r_count == '0);
    assign is_full  = (r_count == FULL_CNT);
    assign cnt_dec  = r_count - CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_func;
            r_idx   <= i_index;
            r_value <= i_value;
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        addr     = r_idx;
        unique case (r_func) inside
            FN_PUSH: begin
                if (is_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    addr    = r_count[IDX_W-1:0];
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_POP: begin
                if (is_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    rd_en   = 1'b1;
                    addr    = cnt_dec[IDX_W-1:0];
                    n_count = cnt_dec;
                end
            end
            FN_PEEK, FN_WRITE: begin
                if (is_empty) begin
                    n_status = ST_UNDERFLOW;
                end else if (CNT_W'(r_idx) >= r_count) begin
                    n_status = ST_BOUNDS;
                end else if (r_func == FN_PEEK) begin
                    rd_en = 1'b1;
                end else begin
                    wr_en = 1'b1;
                end
            end
            FN_CLEAR: n_count = '0;
            default: ;  // unused codes leave the stack as it is
        endcase
    end

    // entry store: one port, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[addr] <= r_value;
        end
        if (i_cmd.exec && rd_en) begin
            r_rd_data <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_hit   <= 1'b0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
            r_hit   <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    assign o_data   = r_hit ? r_rd_data : '0;
    assign o_status = r_status;
    assign o_count  = r_count;
    assign o_empty  = is_empty;
    assign o_full   = is_full;

endmodule

// File: rtl/lifo_stack_with_indexed_access_unit.sv
`timescale 1ns / 1ps
// LIFO stack of signed 32-bit words with push, pop, indexed peek, indexed
// overwrite and clear.
//
// Channels: i_cmd carries one command word (func, index, value); o_rsp
// returns one response word per command (data, status, count, empty_res,
// full_res). Both use valid/ready; a word moves when both are high.
// Timing: a taken command is captured, then executed in S_EXEC, and its
// response is registered and valid in S_OUT. A new command is taken only
// after the response to the last one has been accepted, as set by the
// capture / execute / respond sequence around the single-port entry
// memory, whose read data is registered.
// Reset: the fill count is cleared, the stack reads as empty and i_cmd is
// ready; stored words are not cleared and are only read once written.
// Stall: while o_rsp.ready is low the response holds and no command is
// taken. Failed operations report status and leave the stack unchanged.
// Uses lifo_pkg, lifo_in_if, lifo_out_if, lifo_ctrl and lifo_dp.
module lifo_stack_with_indexed_access_unit #(
    parameter int DEPTH = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lifo_in_if.sink           i_cmd,
    lifo_out_if.source        o_rsp
);
    import lifo_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dp_cmd w_cmd;

    lifo_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    lifo_dp #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_func   (i_cmd.func),
        .i_index  (i_cmd.index),
        .i_value  (i_cmd.value),
        .o_data   (o_rsp.data),
        .o_status (o_rsp.status),
        .o_count  (o_rsp.count),
        .o_empty  (o_rsp.empty_res),
        .o_full   (o_rsp.full_res)
    );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for lifo_stack_with_indexed_access_unit: a directed run,
// then random command words with random idling, all checked against a stack
// predictor. Depends on lifo_pkg, lifo_in_if, lifo_out_if and the DUT from the RTL.
module testbench;
    import lifo_pkg::*;

    localparam int DEPTH       = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int PHASE_ITEMS = 245;
    localparam int N_PHASES    = 5;
    localparam int LONG_HOLD   = 80;
    localparam int IDLE_LIMIT  = 1000;
    localparam int MAX_REPORTS = 10;

    // codes above clear do nothing
    localparam logic [FUNC_W-1:0] FN_SPARE_LO = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0]   data;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    count;
        logic                empty_res;
        logic                full_res;
    } t_stack_rsp;

    class stack_scoreboard;
        logic [WORD_W-1:0] words [DEPTH];
        int                fill;
        t_stack_rsp        pending [$];
        int                mismatches;
        int                rsp_seen;

        function new();
            foreach (words[i]) words[i] = '0;
            fill       = 0;
            mismatches = 0;
            rsp_seen   = 0;
        endfunction

        // Apply one accepted command to the shadow stack and queue its response.
        function void note_command(logic [FUNC_W-1:0] fn, logic [IDX_W-1:0] ix,
                                   logic [WORD_W-1:0] v);
            t_stack_rsp r;
            r        = '0;
            r.status = ST_OK;
            case (fn)
                FN_PUSH: begin
                    if (fill >= DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        words[fill] = v;
                        fill++;
                    end
                end
                FN_POP: begin
                    if (fill == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else begin
                        fill--;
                        r.data = words[fill];
                    end
                end
                FN_PEEK, FN_WRITE: begin
                    if (fill == 0) begin
                        r.status = ST_UNDERFLOW;
                    end else if (int'(ix) >= fill) begin
                        r.status = ST_BOUNDS;
                    end else if (fn == FN_PEEK) begin
                        r.data = words[ix];
                    end else begin
                        words[ix] = v;
                    end
                end
                FN_CLEAR: begin
                    fill = 0;
                end
                default: ;
            endcase
            r.count     = CNT_W'(fill);
            r.empty_res = (fill == 0);
            r.full_res  = (fill == DEPTH);
            pending.push_back(r);
        endfunction

        function void check_response(logic [WORD_W-1:0] d, logic [STATUS_W-1:0] st,
                                     logic [CNT_W-1:0] cnt, logic emp, logic ful);
            t_stack_rsp want;
            rsp_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: response %0d with nothing outstanding: data=%0d status=%0d",
                             rsp_seen, $signed(d), st);
                return;
            end
            want = pending.pop_front();
            if (d !== want.data || st !== want.status || cnt !== want.count ||
                emp !== want.empty_res || ful !== want.full_res) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: response %0d: expected data=%0d status=%0d count=%0d ",
                             rsp_seen, $signed(want.data), want.status, want.count,
                             "empty=%0b full=%0b; got data=%0d status=%0d count=%0d ",
                             want.empty_res, want.full_res, $signed(d), st, cnt,
                             "empty=%0b full=%0b", emp, ful);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   no_idle      = 1'b0;
    bit   hold_off_req = 1'b0;
    int   idle_cycles  = 0;

    stack_scoreboard sb;

    lifo_in_if  #(.IDX_W(IDX_W)) cmd_ch ();
    lifo_out_if #(.CNT_W(CNT_W)) rsp_ch ();

    lifo_stack_with_indexed_access_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_rsp  (rsp_ch)
    );

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one command word and hold it until the block takes it.
    task automatic send_command(input logic [FUNC_W-1:0] fn, input logic [IDX_W-1:0] ix,
                                input logic [WORD_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= fn;
        cmd_ch.index <= ix;
        cmd_ch.value <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    // Stop offering and wait until every outstanding response is back.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_command(FN_POP,   3'd0, 32'd0);
        send_command(FN_PEEK,  3'd0, 32'd0);
        send_command(FN_WRITE, 3'd0, 32'h1111_1111);
        send_command(FN_CLEAR, 3'd0, 32'd0);
        for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++)
            send_command(FN_FUNC_CAST(f), 3'd7, 32'hFFFF_FFFF);
        send_command(FN_PUSH,  3'd0, 32'h8000_0000);
        send_command(FN_PEEK,  3'd1, 32'd0);
        send_command(FN_WRITE, 3'd7, 32'h2222_2222);
        send_command(FN_PUSH,  3'd0, 32'h7FFF_FFFF);
        send_command(FN_PUSH,  3'd0, 32'hFFFF_FFFF);
        send_command(FN_PUSH,  3'd0, 32'h0000_0000);
        send_command(FN_PUSH,  3'd0, 32'h0000_0001);
        send_command(FN_PUSH,  3'd0, 32'h5555_5555);
        send_command(FN_PUSH,  3'd0, 32'hAAAA_AAAA);
        send_command(FN_PUSH,  3'd0, 32'hFFFF_FFFE);
        // stack is full here
        send_command(FN_PUSH,  3'd0, 32'h3333_3333);
        send_command(FN_PEEK,  3'd7, 32'd0);
        send_command(FN_WRITE, 3'd7, 32'h1234_5678);
        send_command(FN_PEEK,  3'd0, 32'd0);
        send_command(FN_WRITE, 3'd0, 32'h7FFF_FFFF);
        send_command(FN_POP,   3'd0, 32'd0);
        send_command(FN_CLEAR, 3'd0, 32'd0);
        send_command(FN_POP,   3'd0, 32'd0);
    endtask

    function automatic logic [FUNC_W-1:0] FN_FUNC_CAST(int f);
        return FUNC_W'(f);
    endfunction

    // Regime 0 balanced, 1 filling, 2 draining.
    task automatic send_random(input int regime);
        logic [FUNC_W-1:0] fn;
        logic [IDX_W-1:0]  ix;
        logic [WORD_W-1:0] v;
        int r, lvl, push_w, pop_w;
        lvl    = sb.fill;
        push_w = (regime == 1) ? 46 : (regime == 2) ? 16 : 32;
        pop_w  = 60 - push_w;
        r      = $urandom_range(0, 99);
        if (r < push_w)                   fn = FN_PUSH;
        else if (r < push_w + pop_w)      fn = FN_POP;
        else if (r < 78)                  fn = FN_PEEK;
        else if (r < 93)                  fn = FN_WRITE;
        else if (r < 96)                  fn = FN_CLEAR;
        else                              fn = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
        if (lvl > 0 && $urandom_range(0, 9) < 8) ix = IDX_W'($urandom_range(0, lvl - 1));
        else                                      ix = IDX_W'($urandom_range(0, DEPTH - 1));
        case ($urandom_range(0, 19))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            default: v = $urandom;
        endcase
        send_command(fn, ix, v);
    endtask

    initial begin
        sb = new();
        cmd_ch.valid <= 1'b0;
        cmd_ch.func  <= FN_PUSH;
        cmd_ch.index <= '0;
        cmd_ch.value <= '0;
        i_rst_n      <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        drain_results();
        for (int ph = 0; ph < N_PHASES; ph++) begin
            no_idle = (ph == 1 || ph == 4);
            // hold the response side while commands keep being offered
            if (ph == 2) hold_off_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++) send_random((k / 40) % 3);
            drain_results();
        end
        no_idle = 1'b0;
        repeat (8) @(posedge i_clk);
        if (sb.pending.size() != 0) begin
            sb.mismatches++;
            $display("ERROR: %0d responses never arrived", sb.pending.size());
        end
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left   = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else if (no_idle) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    rsp_ch.ready <= 1'b1;
                end else begin
                    rsp_ch.ready <= 1'b0;
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
                end
            end
        end
    end

    // Command first, so a word taken at this edge is queued before any check.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.func, cmd_ch.index, cmd_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.data, rsp_ch.status, rsp_ch.count,
                                  rsp_ch.empty_res, rsp_ch.full_res);
            if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("ERROR: no word moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

endmodule

// File: files.f
rtl/lifo_pkg.sv
rtl/lifo_if.sv
rtl/lifo_ctrl.sv
rtl/lifo_dp.sv
rtl/lifo_stack_with_indexed_access_unit.sv
sim/testbench.sv
